// ===== rtl/core/hxd_pkg.sv =====
// Package for the hex text to bytes decoder.
// Item and result types, the per-item result bundle, result kinds and character codes.
// No dependencies.
`default_nettype none

package hxd_pkg;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } hxd_kind_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       char_present;
      logic       end_of_text;
   } hxd_req_type;

   typedef struct packed {
      hxd_kind_type kind;
      logic [7:0]   data_byte;
      logic         final_res;
   } hxd_rsp_type;

   localparam int unsigned MAX_RES = 3;

   // all results caused by one item; res[0] is the oldest
   typedef struct packed {
      logic [1:0]                 cnt;
      hxd_rsp_type [MAX_RES-1:0] res;
   } hxd_bundle_type;

   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_F   = 8'h66;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LO_X   = 8'h78;
   localparam logic [7:0] CH_UP_X   = 8'h58;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NEL    = 8'h85;
   localparam logic [7:0] CH_NBSP   = 8'hA0;
   localparam logic [3:0] HEX_TEN   = 4'd10;

endpackage

`default_nettype wire

// ===== rtl/core/hxd_front.sv =====
// Front end of the hex text decoder: classifies each character, keeps the nibble
// and lookahead state and builds the bundle of results for the item.
// Depends on hxd_pkg.
`default_nettype none

module hxd_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  hxd_pkg::hxd_req_type        req_data,
   output logic                        bundle_push,
   output hxd_pkg::hxd_bundle_type     bundle_data
);
   import hxd_pkg::*;

   logic [3:0] high_nibble_ff, high_nibble_in;
   logic       have_high_ff, have_high_in;
   logic       zero_pending_ff, zero_pending_in;
   logic       discarding_ff, discarding_in;

   logic [7:0] c;
   logic       is_dec, is_lo, is_up, is_hex, is_skip, is_x;
   logic [3:0] val;
   logic [1:0] n;
   logic       stop;
   hxd_rsp_type [MAX_RES-1:0] res;

   assign c = req_data.char_code;

   always_comb begin
      is_dec  = (c >= CH_0) && (c <= CH_9);
      is_lo   = (c >= CH_LO_A) && (c <= CH_LO_F);
      is_up   = (c >= CH_UP_A) && (c <= CH_UP_F);
      is_hex  = is_dec || is_lo || is_up;
      is_skip = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE) || (c == CH_NEL) ||
                (c == CH_NBSP) || (c == CH_COMMA) || (c == CH_DASH) || (c == CH_COLON);
      is_x    = (c == CH_LO_X) || (c == CH_UP_X);
      if (is_dec) begin
         val = 4'(c - CH_0);
      end else if (is_lo) begin
         val = 4'(c - CH_LO_A) + HEX_TEN;
      end else begin
         val = 4'(c - CH_UP_A) + HEX_TEN;
      end
   end

   always_comb begin
      high_nibble_in  = high_nibble_ff;
      have_high_in    = have_high_ff;
      zero_pending_in = zero_pending_ff;
      discarding_in   = discarding_ff;
      n               = '0;
      stop            = 1'b0;
      res             = '0;
      if (discarding_ff) begin
         if (req_data.end_of_text) begin
            discarding_in = 1'b0;
         end
      end else begin
         if (req_data.char_present) begin
            if (zero_pending_in && is_x) begin
               zero_pending_in = 1'b0;
            end else begin
               if (zero_pending_in) begin
                  zero_pending_in = 1'b0;
                  if (have_high_in) begin
                     res[n]       = '{kind: KIND_DATA, data_byte: {high_nibble_in, 4'h0},
                                      final_res: 1'b0};
                     n            = n + 2'd1;
                     have_high_in = 1'b0;
                     high_nibble_in = '0;
                  end else begin
                     high_nibble_in = '0;
                     have_high_in   = 1'b1;
                  end
               end
               if (is_skip) begin
                  zero_pending_in = zero_pending_in;
               end else if (c == CH_0) begin
                  zero_pending_in = 1'b1;
               end else if (!is_hex) begin
                  res[n]          = '{kind: KIND_ERROR, data_byte: 8'h00, final_res: 1'b1};
                  n               = n + 2'd1;
                  high_nibble_in  = '0;
                  have_high_in    = 1'b0;
                  zero_pending_in = 1'b0;
                  discarding_in   = !req_data.end_of_text;
                  stop            = 1'b1;
               end else if (have_high_in) begin
                  res[n]         = '{kind: KIND_DATA, data_byte: {high_nibble_in, val},
                                     final_res: 1'b0};
                  n              = n + 2'd1;
                  have_high_in   = 1'b0;
                  high_nibble_in = '0;
               end else begin
                  high_nibble_in = val;
                  have_high_in   = 1'b1;
               end
            end
         end
         if (req_data.end_of_text && !stop) begin
            if (zero_pending_in) begin
               zero_pending_in = 1'b0;
               if (have_high_in) begin
                  res[n]         = '{kind: KIND_DATA, data_byte: {high_nibble_in, 4'h0},
                                    final_res: 1'b0};
                  n              = n + 2'd1;
                  have_high_in   = 1'b0;
                  high_nibble_in = '0;
               end else begin
                  high_nibble_in = '0;
                  have_high_in   = 1'b1;
               end
            end
            if (have_high_in) begin
               res[n] = '{kind: KIND_DATA, data_byte: {4'h0, high_nibble_in}, final_res: 1'b0};
               n      = n + 2'd1;
            end
            res[n]          = '{kind: KIND_DONE, data_byte: 8'h00, final_res: 1'b1};
            n               = n + 2'd1;
            high_nibble_in  = '0;
            have_high_in    = 1'b0;
            zero_pending_in = 1'b0;
         end
      end
   end

   assign bundle_push     = accept && (n != 2'd0);
   assign bundle_data.cnt = n;
   assign bundle_data.res = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_nibble_ff  <= '0;
         have_high_ff    <= 1'b0;
         zero_pending_ff <= 1'b0;
         discarding_ff   <= 1'b0;
      end else if (accept) begin
         high_nibble_ff  <= high_nibble_in;
         have_high_ff    <= have_high_in;
         zero_pending_ff <= zero_pending_in;
         discarding_ff   <= discarding_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/hxd_queue.sv =====
// Small bundle queue between the decoder front end and the result sequencer.
// Depends on hxd_pkg.
`default_nettype none

module hxd_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  hxd_pkg::hxd_bundle_type  wr_data,
   output logic                     full,
   input  wire logic                rd_en,
   output hxd_pkg::hxd_bundle_type  rd_data,
   output logic                     empty
);
   import hxd_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   hxd_bundle_type mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_wr, do_rd;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/hxd_back.sv =====
// Result sequencer: takes bundles from the queue and hands out their results
// one per pop, oldest first. Depends on hxd_pkg.
`default_nettype none

module hxd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  hxd_pkg::hxd_bundle_type  q_data,
   input  wire logic                q_empty,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output hxd_pkg::hxd_rsp_type     rsp_data
);
   import hxd_pkg::*;

   hxd_bundle_type bundle_ff;
   logic [1:0]     idx_ff;
   logic           valid_ff;
   logic           taken, last, load;

   assign taken     = rsp_pop && valid_ff;
   assign last      = (idx_ff == (bundle_ff.cnt - 2'd1));
   assign load      = !valid_ff || (taken && last);
   assign q_pop     = load && !q_empty;
   assign rsp_empty = !valid_ff;
   assign rsp_data  = bundle_ff.res[idx_ff];

   always_ff @(posedge clock) begin
      if (q_pop) begin
         bundle_ff <= q_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= !q_empty;
         idx_ff   <= '0;
      end else if (taken) begin
         idx_ff   <= idx_ff + 2'd1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/hex_text_to_bytes_decoder.sv =====
// Top level of the hex text to bytes decoder.
// Depends on hxd_pkg, hxd_front, hxd_queue and hxd_back.
//
// Takes one character item per clock whenever req_full is low; req_full rises only
// when QUEUE_DEPTH item bundles (each one to three results) are waiting. Results leave
// one per clock on pop, so the result port is the limit for items that cause more
// than one result. A result reaches the rsp_ ports through the queue entry and then
// the sequencer's bundle register.
`default_nettype none

module hex_text_to_bytes_decoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  hxd_pkg::hxd_req_type  req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output hxd_pkg::hxd_rsp_type  rsp_data
);
   import hxd_pkg::*;

   hxd_bundle_type wr_bundle, rd_bundle;
   logic           accept, wr_en, q_full, q_empty, q_pop;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   hxd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .bundle_push (wr_en),
      .bundle_data (wr_bundle)
   );

   hxd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_data (wr_bundle),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (rd_bundle),
      .empty   (q_empty)
   );

   hxd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (rd_bundle),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/hxd_checker.sv =====
// Port-level checks for the hex text to bytes decoder, bound to the top level.
// Depends on hxd_pkg and hex_text_to_bytes_decoder.
`default_nettype none

module hxd_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_full,
   input wire logic             rsp_empty,
   input wire logic             rsp_pop,
   input hxd_pkg::hxd_rsp_type  rsp_data
);
   import hxd_pkg::*;

   a_data_not_final: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.kind == KIND_DATA) |-> !rsp_data.final_res)
      else $error("data byte marked final");

   a_end_is_final: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.kind == KIND_DONE || rsp_data.kind == KIND_ERROR)) |->
      (rsp_data.final_res && rsp_data.data_byte == 8'h00))
      else $error("done or error result malformed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queue not empty after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind hex_text_to_bytes_decoder hxd_checker u_hxd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire
